/* rtl/core/lpfa_pkg.sv */
`timescale 1ns / 1ps
package lpfa_pkg;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WELL_DEPTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA_SQ     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_SQ    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_SHIFT = 2'd3;

   localparam logic [1:0] MODE_DRAIN_ENERGY = 2'd0;
   localparam logic [1:0] MODE_PAIR         = 2'd1;
   localparam logic [1:0] MODE_DRAIN_FORCE  = 2'd2;

   localparam logic [63:0] MAGMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QONE    = 64'h0000_0001_0000_0000;

   localparam logic [2:0] MUL_LAST  = 3'd5;
   localparam logic [6:0] DIV_LAST  = 7'd95;

   typedef logic [2:0][63:0] force_vec_type;

   typedef struct packed {
      logic        ovf;
      logic [63:0] val;
   } sat_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQ,
      ST_RANGE,
      ST_DIV_S2,
      ST_MUL_S4,
      ST_MUL_S6,
      ST_MUL_W,
      ST_MUL_PE,
      ST_E_SUB,
      ST_E_ADD,
      ST_DIV_G,
      ST_MUL_FM,
      ST_MUL_F,
      ST_RD_I,
      ST_WR_I,
      ST_RD_J,
      ST_WR_J,
      ST_DRAIN_E,
      ST_DRAIN_RD,
      ST_DRAIN_WR
   } state_type;

   function automatic sat_type sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      sat_type     r;
      s = {a[63], a} + {b[63], b};
      r.ovf = s[64] ^ s[63];
      r.val = r.ovf ? (s[64] ? INT_MIN : MAGMAX) : s[63:0];
      return r;
   endfunction

   function automatic sat_type sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      sat_type     r;
      s = {a[63], a} - {b[63], b};
      r.ovf = s[64] ^ s[63];
      r.val = r.ovf ? (s[64] ? INT_MIN : MAGMAX) : s[63:0];
      return r;
   endfunction

   // cap an unsigned magnitude at 2^63-1
   function automatic sat_type mag_cap(input logic [66:0] p);
      sat_type r;
      r.ovf = |p[66:63];
      r.val = r.ovf ? MAGMAX : p[63:0];
      return r;
   endfunction

   function automatic logic [63:0] apply_sign(input logic [63:0] mag, input logic neg);
      return neg ? (~mag + 64'd1) : mag;
   endfunction

endpackage

/* rtl/core/lpfa_if.sv */
`timescale 1ns / 1ps
interface lpfa_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [9:0]         atom_first;
   logic [9:0]         atom_second;
   logic signed [31:0] delta_x;
   logic signed [31:0] delta_y;
   logic signed [31:0] delta_z;

   modport source(output valid, mode, atom_first, atom_second, delta_x, delta_y, delta_z,
                  input ready);
   modport sink(input valid, mode, atom_first, atom_second, delta_x, delta_y, delta_z,
                output ready);
endinterface

interface lpfa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] force_x_out;
   logic signed [63:0] force_y_out;
   logic signed [63:0] force_z_out;
   logic signed [63:0] energy_out;
   logic               overflow;

   modport source(output valid, force_x_out, force_y_out, force_z_out, energy_out, overflow,
                  input ready);
   modport sink(input valid, force_x_out, force_y_out, force_z_out, energy_out, overflow,
                output ready);
endinterface

/* rtl/core/lpfa_mul.sv */
`timescale 1ns / 1ps
module lpfa_mul import lpfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  logic [5:0]  sh,
   output logic        done,
   output logic [63:0] res,
   output logic        ovf
);

   logic         busy_ff;
   logic         done_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [5:0]   sh_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   pos_ff;
   logic [127:0] acc_ff;
   logic [63:0]  res_ff;
   logic         ovf_ff;

   logic [1:0]   sel;
   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [63:0]  prod;
   logic [127:0] pp_sh;
   logic [127:0] shr;
   logic         fin_ovf;

   // one 32x32 partial product per cycle, accumulated in the following cycle
   always_comb begin
      sel     = cnt_ff[1:0];
      a_half  = sel[1] ? a_ff[63:32] : a_ff[31:0];
      b_half  = sel[0] ? b_ff[63:32] : b_ff[31:0];
      prod    = a_half * b_half;
      pp_sh   = {64'd0, pp_ff} << {pos_ff, 5'd0};
      shr     = acc_ff >> sh_ff;
      fin_ovf = |shr[127:63];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == MUL_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         sh_ff  <= sh;
         acc_ff <= '0;
      end else if (busy_ff) begin
         pp_ff  <= prod;
         pos_ff <= {1'b0, sel[1]} + {1'b0, sel[0]};
         if (cnt_ff != 3'd0 && cnt_ff < MUL_LAST) begin
            acc_ff <= acc_ff + pp_sh;
         end
         if (cnt_ff == MUL_LAST) begin
            res_ff <= fin_ovf ? MAGMAX : shr[63:0];
            ovf_ff <= fin_ovf;
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign ovf  = ovf_ff;

endmodule

/* rtl/core/lpfa_div.sv */
`timescale 1ns / 1ps
module lpfa_div import lpfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [47:0] den,
   output logic        done,
   output logic [63:0] res,
   output logic        ovf
);

   logic        busy_ff;
   logic        done_ff;
   logic [6:0]  cnt_ff;
   logic [95:0] num_ff;
   logic [47:0] den_ff;
   logic [47:0] rem_ff;
   logic [63:0] q_ff;
   logic [63:0] res_ff;
   logic        ovf_ff;

   logic [48:0] rem_sh;
   logic        ge;
   logic [48:0] rem_nx;
   logic [63:0] q_nx;
   logic        early;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, num_ff[95]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_nx = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      q_nx   = {q_ff[62:0], ge};
      early  = |q_ff[63:62];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            if (early || cnt_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {num, 32'd0};
         den_ff <= den;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (early) begin
            res_ff <= MAGMAX;
            ovf_ff <= 1'b1;
         end else begin
            num_ff <= {num_ff[94:0], 1'b0};
            // remainder stays below the 48-bit divisor
            rem_ff <= rem_nx[47:0];
            q_ff   <= q_nx;
            if (cnt_ff == DIV_LAST) begin
               res_ff <= q_nx;
               ovf_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign ovf  = ovf_ff;

endmodule

/* rtl/core/lj_pair_force_accumulator_core.sv */
`timescale 1ns / 1ps
// One request at a time. A pair uses two serial divisions of up to 96 steps
// and eleven 64x64 products on one shared 32x32 multiplier. A drain request waits
// for the result register to empty before it loads it.
// Result register sits after the work: one result may wait while the next request runs.
// Reset is synchronous; afterwards the force memory is cleared one atom per cycle,
// all MAX_ATOMS entries, before the first request is accepted. Config writes are always taken.
module lj_pair_force_accumulator_core import lpfa_pkg::*; #(
   parameter int MAX_ATOMS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   lpfa_req_if.sink             req_ch,
   lpfa_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   localparam int AW = $clog2(MAX_ATOMS);
   localparam logic [AW-1:0] LAST_ATOM = AW'(MAX_ATOMS - 1);

   state_type state_ff, state_in;

   logic [31:0] well_depth_ff;
   logic [47:0] sigma_sq_ff;
   logic [47:0] cutoff_sq_ff;
   logic [63:0] energy_shift_ff;

   logic [9:0]  ai_ff;
   logic [9:0]  aj_ff;
   logic [31:0] mag_ff [3];
   logic [2:0]  neg_ff;
   logic [1:0]  k_ff;
   logic [63:0] sum_ff;
   logic [47:0] r2_ff;
   logic [63:0] s2_ff;
   logic [63:0] t_ff;
   logic [63:0] s6_ff;
   logic [63:0] e_ff;
   logic [63:0] dm_ff;
   logic        dneg_ff;
   logic        fneg_ff;
   logic [63:0] pe_ff;
   logic [63:0] g_ff;
   logic [63:0] fm_ff;
   force_vec_type f_ff;
   logic [63:0] energy_ff;
   logic        ovf_ff;
   logic        mul_pend_ff;
   logic        div_pend_ff;
   logic [AW-1:0] clr_cnt_ff;

   force_vec_type mem [MAX_ATOMS];
   force_vec_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   force_vec_type mem_wd;

   logic          rsp_valid_ff;
   force_vec_type out_force_ff;
   logic [63:0]   out_energy_ff;
   logic          out_ovf_ff;
   logic          out_load;
   logic          out_free;

   logic        mul_start, mul_done, mul_ovf;
   logic [63:0] mul_a, mul_b, mul_res;
   logic [5:0]  mul_sh;
   logic        div_start, div_done, div_ovf;
   logic [63:0] div_num, div_res;

   logic          req_fire;
   logic [16:0]   req_ai_ext, req_aj_ext, ai_ext, aj_ext;
   logic          req_pair_ok;
   logic          ai_ok;
   logic [AW-1:0] ai_addr, aj_addr;
   logic [31:0]   req_d [3];
   logic [55:0]   r2_full;
   sat_type       cap4, cap6, s6x2, esub, eadd;
   sat_type       wr_sat [3];
   logic          wr_ovf;
   logic          ovf_set;

   lpfa_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .sh    (mul_sh),
      .done  (mul_done),
      .res   (mul_res),
      .ovf   (mul_ovf)
   );

   lpfa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (r2_ff),
      .done  (div_done),
      .res   (div_res),
      .ovf   (div_ovf)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      req_ai_ext  = 17'(req_ch.atom_first);
      req_aj_ext  = 17'(req_ch.atom_second);
      req_pair_ok = (req_ch.atom_first != req_ch.atom_second)
                    && (req_ai_ext < 17'(MAX_ATOMS)) && (req_aj_ext < 17'(MAX_ATOMS));
      ai_ext  = 17'(ai_ff);
      aj_ext  = 17'(aj_ff);
      ai_ok   = ai_ext < 17'(MAX_ATOMS);
      ai_addr = ai_ext[AW-1:0];
      aj_addr = aj_ext[AW-1:0];
      req_d[0] = req_ch.delta_x;
      req_d[1] = req_ch.delta_y;
      req_d[2] = req_ch.delta_z;
      r2_full = sum_ff[63:8];
      cap4 = mag_cap(67'({mul_res, 2'b00}));
      cap6 = mag_cap(67'({div_res, 2'b00}) + 67'({div_res, 1'b0}));
      s6x2 = mag_cap(67'({s6_ff, 1'b0}));
      esub = sat_sub(pe_ff, energy_shift_ff);
      eadd = sat_add(energy_ff, pe_ff);
      for (int k = 0; k < 3; k++) begin
         wr_sat[k] = (state_ff == ST_WR_I) ? sat_add(rd_data_ff[k], f_ff[k])
                                           : sat_sub(rd_data_ff[k], f_ff[k]);
      end
      wr_ovf = wr_sat[0].ovf | wr_sat[1].ovf | wr_sat[2].ovf;
      out_free = !rsp_valid_ff || rsp_ch.ready;
   end

   // multiplier and divider operand select
   always_comb begin
      mul_a   = fm_ff;
      mul_b   = 64'(mag_ff[k_ff]);
      mul_sh  = 6'd32;
      div_num = 64'(sigma_sq_ff);
      case (state_ff)
         ST_SQ: begin
            mul_a  = 64'(mag_ff[k_ff]);
            mul_b  = 64'(mag_ff[k_ff]);
            mul_sh = 6'd0;
         end
         ST_MUL_S4: begin
            mul_a = s2_ff;
            mul_b = s2_ff;
         end
         ST_MUL_S6: begin
            mul_a = t_ff;
            mul_b = s2_ff;
         end
         ST_MUL_W: begin
            mul_a = 64'({well_depth_ff, 16'd0});
            mul_b = s6_ff;
         end
         ST_MUL_PE: begin
            mul_a = e_ff;
            mul_b = dm_ff;
         end
         ST_MUL_FM: begin
            mul_a = g_ff;
            mul_b = dm_ff;
         end
         ST_MUL_F: begin
            mul_sh = 6'd20;
         end
         ST_DIV_G: begin
            div_num = e_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = ai_addr;
      mem_wd    = '0;
      rd_addr   = ai_addr;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_ff;
            if (clr_cnt_ff == LAST_ATOM) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.mode)
                  MODE_DRAIN_ENERGY: state_in = ST_DRAIN_E;
                  MODE_PAIR:         state_in = req_pair_ok ? ST_SQ : ST_IDLE;
                  MODE_DRAIN_FORCE:  state_in = ST_DRAIN_RD;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQ: begin
            mul_start = !mul_pend_ff;
            if (mul_done && k_ff == 2'd2) state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (r2_full == '0 || r2_full > 56'(cutoff_sq_ff)) state_in = ST_IDLE;
            else state_in = ST_DIV_S2;
         end
         ST_DIV_S2: begin
            div_start = !div_pend_ff;
            if (div_done) state_in = ST_MUL_S4;
         end
         ST_MUL_S4: begin
            mul_start = !mul_pend_ff;
            if (mul_done) state_in = ST_MUL_S6;
         end
         ST_MUL_S6: begin
            mul_start = !mul_pend_ff;
            if (mul_done) state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            mul_start = !mul_pend_ff;
            if (mul_done) state_in = ST_MUL_PE;
         end
         ST_MUL_PE: begin
            mul_start = !mul_pend_ff;
            if (mul_done) state_in = ST_E_SUB;
         end
         ST_E_SUB: state_in = ST_E_ADD;
         ST_E_ADD: state_in = ST_DIV_G;
         ST_DIV_G: begin
            div_start = !div_pend_ff;
            if (div_done) state_in = ST_MUL_FM;
         end
         ST_MUL_FM: begin
            mul_start = !mul_pend_ff;
            if (mul_done) state_in = ST_MUL_F;
         end
         ST_MUL_F: begin
            mul_start = !mul_pend_ff;
            if (mul_done && k_ff == 2'd2) state_in = ST_RD_I;
         end
         ST_RD_I: state_in = ST_WR_I;
         ST_WR_I: begin
            mem_we = 1'b1;
            for (int k = 0; k < 3; k++) mem_wd[k] = wr_sat[k].val;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            rd_addr  = aj_addr;
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            mem_we = 1'b1;
            mem_wa = aj_addr;
            for (int k = 0; k < 3; k++) mem_wd[k] = wr_sat[k].val;
            state_in = ST_IDLE;
         end
         ST_DRAIN_E: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN_RD: state_in = ST_DRAIN_WR;
         ST_DRAIN_WR: begin
            if (out_free) begin
               out_load = 1'b1;
               mem_we   = ai_ok;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ovf_set = (mul_done && mul_ovf) || (div_done && div_ovf);
      case (state_ff)
         ST_MUL_W: ovf_set = ovf_set || (mul_done && cap4.ovf);
         ST_DIV_G: ovf_set = ovf_set || (div_done && (cap6.ovf || s6x2.ovf));
         ST_E_SUB: ovf_set = ovf_set || esub.ovf;
         ST_E_ADD: ovf_set = ovf_set || eadd.ovf;
         ST_WR_I, ST_WR_J: ovf_set = ovf_set || wr_ovf;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         mul_pend_ff     <= 1'b0;
         div_pend_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         energy_ff       <= '0;
         ovf_ff          <= 1'b0;
         well_depth_ff   <= '0;
         sigma_sq_ff     <= '0;
         cutoff_sq_ff    <= '0;
         energy_shift_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (mul_start) mul_pend_ff <= 1'b1;
         else if (mul_done) mul_pend_ff <= 1'b0;
         if (div_start) div_pend_ff <= 1'b1;
         else if (div_done) div_pend_ff <= 1'b0;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_E_ADD) energy_ff <= eadd.val;
         else if (state_ff == ST_DRAIN_E && out_load) energy_ff <= '0;
         if (ovf_set) ovf_ff <= 1'b1;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WELL_DEPTH:   well_depth_ff   <= csr_wdata[31:0];
               CSR_SIGMA_SQ:     sigma_sq_ff     <= csr_wdata[47:0];
               CSR_CUTOFF_SQ:    cutoff_sq_ff    <= csr_wdata[47:0];
               CSR_ENERGY_SHIFT: energy_shift_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // pair datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ai_ff  <= req_ch.atom_first;
               aj_ff  <= req_ch.atom_second;
               sum_ff <= '0;
               k_ff   <= '0;
               for (int k = 0; k < 3; k++) begin
                  neg_ff[k] <= req_d[k][31];
                  mag_ff[k] <= req_d[k][31] ? (~req_d[k] + 32'd1) : req_d[k];
               end
            end
         end
         ST_SQ: begin
            if (mul_done) begin
               sum_ff <= sum_ff + mul_res;
               k_ff   <= k_ff + 2'd1;
            end
         end
         ST_RANGE: r2_ff <= r2_full[47:0];
         ST_DIV_S2: if (div_done) s2_ff <= div_res;
         ST_MUL_S4: if (mul_done) t_ff <= mul_res;
         ST_MUL_S6: if (mul_done) s6_ff <= mul_res;
         ST_MUL_W: begin
            if (mul_done) begin
               e_ff    <= cap4.val;
               dneg_ff <= s6_ff < QONE;
               dm_ff   <= (s6_ff < QONE) ? (QONE - s6_ff) : (s6_ff - QONE);
            end
         end
         ST_MUL_PE: if (mul_done) pe_ff <= apply_sign(mul_res, dneg_ff);
         ST_E_SUB: pe_ff <= esub.val;
         ST_DIV_G: begin
            if (div_done) begin
               g_ff    <= cap6.val;
               fneg_ff <= s6x2.val < QONE;
               dm_ff   <= (s6x2.val < QONE) ? (QONE - s6x2.val) : (s6x2.val - QONE);
            end
         end
         ST_MUL_FM: begin
            if (mul_done) begin
               fm_ff <= mul_res;
               k_ff  <= '0;
            end
         end
         ST_MUL_F: begin
            if (mul_done) begin
               f_ff[k_ff] <= apply_sign(mul_res, fneg_ff ^ neg_ff[k_ff]);
               k_ff       <= k_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ovf_ff <= ovf_ff;
         if (state_ff == ST_DRAIN_E) begin
            out_force_ff  <= '0;
            out_energy_ff <= energy_ff;
         end else begin
            out_force_ff  <= ai_ok ? rd_data_ff : '0;
            out_energy_ff <= '0;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.force_x_out = $signed(out_force_ff[0]);
   assign rsp_ch.force_y_out = $signed(out_force_ff[1]);
   assign rsp_ch.force_z_out = $signed(out_force_ff[2]);
   assign rsp_ch.energy_out  = $signed(out_energy_ff);
   assign rsp_ch.overflow    = out_ovf_ff;

   a_mul_done_pending: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> mul_pend_ff)
      else $error("multiplier finished without a pending operation");

   a_div_done_pending: assert property (@(posedge clock) disable iff (reset)
      div_done |-> div_pend_ff)
      else $error("divider finished without a pending operation");

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      !$fell(ovf_ff))
      else $error("sticky overflow cleared outside reset");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAIN_E || $past(state_ff) == ST_DRAIN_WR))
      else $error("result raised outside a drain request");

endmodule
